>>> rtl/sbm_pkg.sv
// Shared types and constants for the serial bank mapper with frame timer.
// No dependencies; sbm_ctrl, sbm_timer and the core import this package.
package sbm_pkg;

	// Item kinds carried in the func field
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// Control register reset values
	localparam logic [4:0] CTRL0_RESET = 5'h0C;
	localparam logic [4:0] CTRL1_RESET = 5'h00;
	localparam logic [4:0] CTRL2_RESET = 5'h00;
	localparam logic [4:0] CTRL3_RESET = 5'h10;

	// Bit 7 reset write forces these bits into control register 0
	localparam logic [4:0] CTRL0_RESET_OR = 5'h0C;

	// Serial port: five bits make one register value
	localparam logic [2:0] SHIFT_BITS = 3'd5;

	// Warm-up writes before banks and timer follow the registers
	localparam logic [1:0] WARMUP_DONE = 2'd2;

	// Fixed banks of the 32-bank window
	localparam logic [4:0] BANK_HI_LOW  = 5'd16;
	localparam logic [4:0] BANK_HI_HIGH = 5'd17;
	localparam logic [4:0] BANK_FIX_C   = 5'd30;
	localparam logic [4:0] BANK_FIX_D   = 5'd31;

	// Frame timer
	localparam logic [31:0] TIMER_STEP    = 32'd29781;
	localparam logic [31:0] IRQ_OR_MASK   = 32'h21FF_FFFF;
	localparam logic [31:0] IRQ_TEST_MASK = 32'h3E00_0000;

	// Control register indexes
	localparam logic [1:0] REG_CTRL = 2'd0;
	localparam logic [1:0] REG_CHR0 = 2'd1;
	localparam logic [1:0] REG_CHR1 = 2'd2;
	localparam logic [1:0] REG_PRG  = 2'd3;

	typedef struct packed {
		logic        func;
		logic [15:0] cpu_addr;
		logic [7:0]  cpu_data;
		logic [8:0]  line_number;
	} sbm_item_t;

	typedef struct packed {
		logic [4:0] prg_bank_a;
		logic [4:0] prg_bank_b;
		logic [4:0] prg_bank_c;
		logic [4:0] prg_bank_d;
		logic [1:0] mirror_mode;
		logic       irq_pulse;
	} sbm_result_t;

	typedef struct packed {
		logic [4:0] a;
		logic [4:0] b;
		logic [4:0] c;
		logic [4:0] d;
	} bank_map_t;

	// Timer control issued by a post-warm-up write
	typedef struct packed {
		logic clear;
		logic arm;
	} timer_cmd_t;

endpackage

>>> rtl/sbm_stream_if.sv
// Valid/ready channel carrying one item per handshake.
// Payload type is supplied by the instantiating level (see sbm_pkg).
interface sbm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/sbm_ctrl.sv
// Serial write port, control registers, warm-up count and PRG bank map.
// Depends on sbm_pkg. Outputs the post-item bank map, mirroring and timer command.
module sbm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_go,
	input  logic [15:0]        cpu_addr,
	input  logic [7:0]         cpu_data,
	output sbm_pkg::bank_map_t bank_nxt,
	output logic [1:0]         mirror_nxt,
	output sbm_pkg::timer_cmd_t tcmd
);
	import sbm_pkg::*;

	logic [4:0]       shift_q, shift_nxt, shift_ins;
	logic [2:0]       count_q, count_nxt, count_inc;
	logic [3:0][4:0]  ctrl_q, ctrl_nxt;
	logic [1:0]       warm_q, warm_nxt;
	bank_map_t        bank_q, bank_calc;
	logic [1:0]       sel;
	logic             banks_upd;
	logic [4:0]       r0, r1, r3;

	assign sel = cpu_addr[14:13];

	// Serial shift and register commit
	always_comb begin
		shift_nxt = shift_q;
		count_nxt = count_q;
		ctrl_nxt  = ctrl_q;
		shift_ins = shift_q | (5'(cpu_data[0]) << count_q);
		count_inc = count_q + 3'd1;
		if (wr_go) begin
			if (cpu_data[7]) begin
				shift_nxt = '0;
				count_nxt = '0;
				if (sel == REG_CTRL) begin
					ctrl_nxt[REG_CTRL] = ctrl_q[REG_CTRL] | CTRL0_RESET_OR;
				end
			end else if (count_inc == SHIFT_BITS) begin
				ctrl_nxt[sel] = shift_ins;
				shift_nxt     = '0;
				count_nxt     = '0;
			end else begin
				shift_nxt = shift_ins;
				count_nxt = count_inc;
			end
		end
	end

	// Warm-up: first two writes leave banks and timer alone
	always_comb begin
		warm_nxt  = warm_q;
		banks_upd = 1'b0;
		if (wr_go) begin
			if (warm_q != WARMUP_DONE) begin
				warm_nxt = warm_q + 2'd1;
			end else begin
				banks_upd = 1'b1;
			end
		end
	end

	// Bank decode from the freshly updated registers
	assign r0 = ctrl_nxt[REG_CTRL];
	assign r1 = ctrl_nxt[REG_CHR0];
	assign r3 = ctrl_nxt[REG_PRG];

	always_comb begin
		if (r1[3]) begin
			if (r0[3]) begin
				if (r0[2]) begin
					bank_calc = '{a: {1'b1, r3[2:0], 1'b0}, b: {1'b1, r3[2:0], 1'b1},
						c: BANK_FIX_C, d: BANK_FIX_D};
				end else begin
					bank_calc = '{a: BANK_HI_LOW, b: BANK_HI_HIGH,
						c: {1'b1, r3[2:0], 1'b0}, d: {1'b1, r3[2:0], 1'b1}};
				end
			end else begin
				bank_calc = '{a: {1'b1, r3[2:1], 2'd0}, b: {1'b1, r3[2:1], 2'd1},
					c: {1'b1, r3[2:1], 2'd2}, d: {1'b1, r3[2:1], 2'd3}};
			end
		end else begin
			bank_calc = '{a: {1'b0, r1[2:1], 2'd0}, b: {1'b0, r1[2:1], 2'd1},
				c: {1'b0, r1[2:1], 2'd2}, d: {1'b0, r1[2:1], 2'd3}};
		end
	end

	assign bank_nxt   = banks_upd ? bank_calc : bank_q;
	// Mirroring tracks register 0 bits 1:0 after every write
	assign mirror_nxt = ctrl_nxt[REG_CTRL][1:0];

	assign tcmd.clear = banks_upd & r1[4];
	assign tcmd.arm   = banks_upd & ~r1[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q          <= '0;
			count_q          <= '0;
			ctrl_q[REG_CTRL] <= CTRL0_RESET;
			ctrl_q[REG_CHR0] <= CTRL1_RESET;
			ctrl_q[REG_CHR1] <= CTRL2_RESET;
			ctrl_q[REG_PRG]  <= CTRL3_RESET;
			warm_q           <= '0;
			bank_q           <= '{a: 5'd0, b: 5'd1, c: 5'd2, d: 5'd3};
		end else begin
			shift_q <= shift_nxt;
			count_q <= count_nxt;
			ctrl_q  <= ctrl_nxt;
			warm_q  <= warm_nxt;
			bank_q  <= bank_nxt;
		end
	end

endmodule

>>> rtl/sbm_timer.sv
// Frame timer: 32-bit counter stepped on scanline 0, with IRQ detect.
// Depends on sbm_pkg for the step and mask constants.
module sbm_timer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_go,
	input  sbm_pkg::timer_cmd_t tcmd,
	output logic                irq_nxt
);
	import sbm_pkg::*;

	logic [31:0] count_q, count_sum, count_view;
	logic        en_q;

	assign count_sum  = count_q + TIMER_STEP;
	assign count_view = en_q ? count_sum : count_q;
	// Bits 28:25 all set (bit 29 is forced by the OR mask)
	assign irq_nxt    = tick_go && (((count_view | IRQ_OR_MASK) & IRQ_TEST_MASK)
		== IRQ_TEST_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			en_q    <= 1'b0;
		end else begin
			if (tcmd.clear) begin
				count_q <= '0;
				en_q    <= 1'b0;
			end else if (tcmd.arm) begin
				en_q <= 1'b1;
			end else if (tick_go && en_q) begin
				count_q <= count_sum;
			end
		end
	end

endmodule

>>> rtl/serial_bank_mapper_with_frame_timer_core.sv
// An accepted item waits in the input register and moves into the result
// register once that register is free or its result is being taken.
// Throughput: one item per cycle; input register and result register each
// pass an item every cycle in which the result is free or taken.
// Reset (arst_n low, asynchronous): pipeline empty, control registers
// 0x0C/0/0/0x10, banks 0..3, timer cleared and disabled, warm-up restarted.
module serial_bank_mapper_with_frame_timer_core (
	input  logic clk,
	input  logic arst_n,
	sbm_stream_if.sink   cmd,
	sbm_stream_if.source rsp
);
	import sbm_pkg::*;

	sbm_item_t   item_s1;
	logic        valid_s1;
	logic        advance;
	logic        wr_go, tick_go;
	bank_map_t   bank_nxt;
	logic [1:0]  mirror_nxt;
	logic        irq_nxt;
	timer_cmd_t  tcmd;
	sbm_result_t rsp_data_q;
	logic        rsp_valid_q;

	// Handshake: stage 1 moves into the result register when that register is free or its result is taken
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign wr_go     = advance && (item_s1.func == FUNC_WRITE);
	assign tick_go   = advance && (item_s1.func == FUNC_TICK) && (item_s1.line_number == '0);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
	end

	sbm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_go      (wr_go),
		.cpu_addr   (item_s1.cpu_addr),
		.cpu_data   (item_s1.cpu_data),
		.bank_nxt   (bank_nxt),
		.mirror_nxt (mirror_nxt),
		.tcmd       (tcmd)
	);

	sbm_timer u_timer (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_go (tick_go),
		.tcmd    (tcmd),
		.irq_nxt (irq_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_data_q.prg_bank_a  <= bank_nxt.a;
			rsp_data_q.prg_bank_b  <= bank_nxt.b;
			rsp_data_q.prg_bank_c  <= bank_nxt.c;
			rsp_data_q.prg_bank_d  <= bank_nxt.d;
			rsp_data_q.mirror_mode <= mirror_nxt;
			rsp_data_q.irq_pulse   <= irq_nxt;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

`ifndef ASSERT_OFF
	// A held stage-1 item is never dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stage-1 item lost while stalled");

	// Input side never blocks while the result side can move
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp_valid_q || rsp.ready) |-> cmd.ready)
		else $error("input stalled with free result register");

	// Every item moved forward shows up as a result
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("advanced item produced no result");

	// Timer command and tick never come from the same item
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!((tcmd.clear || tcmd.arm) && tick_go))
		else $error("timer command and tick together");
`endif

endmodule

>>> tb/tb_serial_bank_mapper_with_frame_timer_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for serial_bank_mapper_with_frame_timer_core.
// Depends on rtl/sbm_pkg.sv, rtl/sbm_stream_if.sv and the core itself.
module tb_serial_bank_mapper_with_frame_timer_core;
	import sbm_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD   = 400;
	localparam int TIMER_TICKS = 200;
	localparam int RAND_ITEMS  = 1370;

	typedef struct {
		sbm_item_t item;
		bit        wait_drain;
	} stim_t;

	typedef enum int {RX_FREE, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;

	logic clk;
	logic arst_n;
	logic run = 1'b0;

	sbm_stream_if #(.payload_t(sbm_item_t))   cmd_if ();
	sbm_stream_if #(.payload_t(sbm_result_t)) rsp_if ();

	serial_bank_mapper_with_frame_timer_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	// Mapper state as the block should hold it
	logic [4:0]  pred_shift  = '0;
	logic [2:0]  pred_count  = '0;
	logic [4:0]  pred_ctrl [4] = '{CTRL0_RESET, CTRL1_RESET, CTRL2_RESET, CTRL3_RESET};
	bank_map_t   pred_banks  = '{a: 5'd0, b: 5'd1, c: 5'd2, d: 5'd3};
	logic [1:0]  pred_mirror = '0;
	logic [31:0] frame_count = '0;
	logic        timer_on    = 1'b0;
	logic [1:0]  warmup      = '0;

	stim_t       tx_items [$];
	sbm_result_t bank_results [$];
	stim_t       next_item;
	sbm_result_t want;

	int  fail_count   = 0;
	int  results_seen = 0;
	int  idle_cycles  = 0;
	bit  cmd_taken    = 1'b0;
	int  burst_left   = 1;
	int  gap_left     = 0;
	int  hold_left    = 0;
	bit  hold_done    = 1'b0;
	int  mode_left    = 0;
	int  rx_phase     = 0;
	rx_mode_t rx_mode = RX_FREE;

	// Clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Bank and timer update done by every write past the warm-up
	function automatic void remap_banks();
		logic [4:0] base;
		if (pred_ctrl[REG_CHR0][3]) begin
			if (pred_ctrl[REG_CTRL][3]) begin
				base = 5'({pred_ctrl[REG_PRG][2:0], 1'b0}) + BANK_HI_LOW;
				if (pred_ctrl[REG_CTRL][2])
					pred_banks = '{a: base, b: base + 5'd1, c: BANK_FIX_C, d: BANK_FIX_D};
				else
					pred_banks = '{a: BANK_HI_LOW, b: BANK_HI_HIGH, c: base, d: base + 5'd1};
			end else begin
				base = 5'({pred_ctrl[REG_PRG][2:1], 2'b00}) + BANK_HI_LOW;
				pred_banks = '{a: base, b: base + 5'd1, c: base + 5'd2, d: base + 5'd3};
			end
		end else begin
			base = 5'({pred_ctrl[REG_CHR0][2:1], 2'b00});
			pred_banks = '{a: base, b: base + 5'd1, c: base + 5'd2, d: base + 5'd3};
		end
		// bit 4 of register 1 stops and clears the timer
		if (pred_ctrl[REG_CHR0][4]) begin
			frame_count = '0;
			timer_on = 1'b0;
		end else begin
			timer_on = 1'b1;
		end
	endfunction

	// Advance the mapper by one item and return the result it gives
	function automatic sbm_result_t mapper_step(sbm_item_t it);
		logic [1:0]  sel;
		logic        irq;
		sbm_result_t r;
		sel = it.cpu_addr[14:13];
		irq = 1'b0;
		if (it.func == FUNC_WRITE) begin
			if (it.cpu_data[7]) begin
				pred_shift = '0;
				pred_count = '0;
				if (sel == REG_CTRL)
					pred_ctrl[REG_CTRL] = pred_ctrl[REG_CTRL] | CTRL0_RESET_OR;
			end else begin
				pred_shift = pred_shift | (5'(it.cpu_data[0]) << pred_count);
				pred_count = pred_count + 3'd1;
				if (pred_count == SHIFT_BITS) begin
					pred_ctrl[sel] = pred_shift;
					pred_shift = '0;
					pred_count = '0;
				end
			end
			pred_mirror = pred_ctrl[REG_CTRL][1:0];
			if (warmup < WARMUP_DONE)
				warmup = warmup + 2'd1;
			else
				remap_banks();
		end else if (it.line_number == '0) begin
			if (timer_on)
				frame_count = frame_count + TIMER_STEP;
			irq = ((frame_count | IRQ_OR_MASK) & IRQ_TEST_MASK) == IRQ_TEST_MASK;
		end
		r.prg_bank_a  = pred_banks.a;
		r.prg_bank_b  = pred_banks.b;
		r.prg_bank_c  = pred_banks.c;
		r.prg_bank_d  = pred_banks.d;
		r.mirror_mode = pred_mirror;
		r.irq_pulse   = irq;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned got_v);
		if (exp_v != got_v) begin
			if (fail_count < 100)
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	task automatic add_item(input logic func, input logic [15:0] addr, input logic [7:0] data,
			input logic [8:0] line, input bit drain);
		stim_t s;
		s.item.func        = func;
		s.item.cpu_addr    = addr;
		s.item.cpu_data    = data;
		s.item.line_number = line;
		s.wait_drain       = drain;
		tx_items.push_back(s);
	endtask

	// Five serial writes, LSB first, with junk in the unused data bits
	task automatic add_serial(input logic [15:0] addr, input logic [4:0] value,
			input logic [6:0] fill);
		for (int i = 0; i < 5; i++)
			add_item(FUNC_WRITE, addr, {1'b0, fill[6:1], value[i]}, 9'($urandom), 1'b0);
	endtask

	// Register load with random content, now and then broken by a bit 7 write
	task automatic add_random_frame();
		logic [1:0] sel;
		logic [4:0] value;
		int         cut;
		sel   = 2'($urandom);
		value = 5'($urandom);
		cut   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : 5;
		for (int i = 0; i < 5; i++) begin
			if (i == cut)
				add_item(FUNC_WRITE, {1'($urandom), 2'($urandom), 13'($urandom)},
					{1'b1, 7'($urandom)}, 9'($urandom), 1'b0);
			add_item(FUNC_WRITE, {1'($urandom), sel, 13'($urandom)},
				{1'b0, 6'($urandom), value[i]}, 9'($urandom), 1'b0);
		end
	endtask

	// Sender: bursts of items with random gaps
	always @(negedge clk) begin
		if (run) begin
			if (!cmd_if.valid || cmd_taken) begin
				if (gap_left != 0) begin
					gap_left--;
					cmd_if.valid <= 1'b0;
				end else if (tx_items.size() != 0
						&& !(tx_items[0].wait_drain && bank_results.size() != 0)) begin
					next_item = tx_items.pop_front();
					cmd_if.data  <= next_item.item;
					cmd_if.valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern in stretches, plus one long hold-off
	always @(negedge clk) begin
		if (run) begin
			if (hold_left != 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (!hold_done && results_seen >= 100) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
				rsp_if.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end else begin
					mode_left--;
				end
				rx_phase++;
				case (rx_mode)
					RX_FREE:   rsp_if.ready <= 1'b1;
					RX_HALF:   rsp_if.ready <= 1'($urandom_range(0, 1));
					RX_MOSTLY: rsp_if.ready <= ($urandom_range(0, 99) < 85);
					default:   rsp_if.ready <= (rx_phase % 3 == 0);
				endcase
			end
		end
	end

	// Monitor: check results in order, predict each accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_taken <= 1'b0;
		end else begin
			cmd_taken <= cmd_if.valid && cmd_if.ready;
			if (rsp_if.valid && rsp_if.ready) begin
				if (bank_results.size() == 0) begin
					if (fail_count < 100)
						$error("result arrived with no item outstanding");
					fail_count++;
				end else begin
					want = bank_results.pop_front();
					check_field("prg_bank_a", want.prg_bank_a, rsp_if.data.prg_bank_a);
					check_field("prg_bank_b", want.prg_bank_b, rsp_if.data.prg_bank_b);
					check_field("prg_bank_c", want.prg_bank_c, rsp_if.data.prg_bank_c);
					check_field("prg_bank_d", want.prg_bank_d, rsp_if.data.prg_bank_d);
					check_field("mirror_mode", want.mirror_mode, rsp_if.data.mirror_mode);
					check_field("irq_pulse", want.irq_pulse, rsp_if.data.irq_pulse);
				end
				results_seen++;
			end
			if (cmd_if.valid && cmd_if.ready)
				bank_results.push_back(mapper_step(cmd_if.data));
		end
	end

	// Watchdog on handshake progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int start;
		arst_n       = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.data  = '0;
		rsp_if.ready = 1'b0;

		// Directed: ticks before arming, reset writes, warm-up, bank modes
		add_item(FUNC_TICK, 16'hFFFF, 8'hFF, 9'd0, 1'b0);
		add_item(FUNC_TICK, 16'h0000, 8'h00, 9'd511, 1'b0);
		add_item(FUNC_WRITE, 16'hFFFF, 8'hFF, 9'd511, 1'b0);
		add_item(FUNC_WRITE, 16'h8000, 8'h80, 9'd0, 1'b0);
		add_serial(16'hA000, 5'h08, 7'h7F);
		add_serial(16'h7FFF, 5'h07, 7'h00);
		add_item(FUNC_WRITE, 16'h0000, 8'h01, 9'd0, 1'b0);
		add_item(FUNC_WRITE, 16'h0000, 8'h7E, 9'd0, 1'b0);
		add_item(FUNC_WRITE, 16'h4000, 8'h80, 9'd0, 1'b0);
		add_item(FUNC_TICK, 16'h0000, 8'h00, 9'd0, 1'b0);
		add_serial(16'h1FFF, 5'h13, 7'h55);
		add_item(FUNC_TICK, 16'h0000, 8'h00, 9'd1, 1'b0);

		// Armed timer: a stretch of ticks, mostly on scanline 0
		add_item(FUNC_TICK, 16'($urandom), 8'($urandom), 9'd0, 1'b1);
		repeat (TIMER_TICKS)
			add_item(FUNC_TICK, 16'($urandom), 8'($urandom),
				($urandom_range(0, 63) == 0) ? 9'($urandom) : 9'd0, 1'b0);

		// Random: mostly register loads and ticks, some raw noise
		add_item(1'($urandom), 16'($urandom), 8'($urandom), 9'($urandom), 1'b1);
		start = tx_items.size();
		while (tx_items.size() < start + RAND_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       add_item(1'($urandom), 16'($urandom), 8'($urandom),
							9'($urandom), 1'b0);
				1, 2, 3: add_item(FUNC_TICK, 16'($urandom), 8'($urandom),
							($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'd0, 1'b0);
				default: add_random_frame();
			endcase
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run <= 1'b1;
		@(negedge clk);

		while (tx_items.size() != 0 || cmd_if.valid || bank_results.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/sbm_pkg.sv
rtl/sbm_stream_if.sv
rtl/sbm_ctrl.sv
rtl/sbm_timer.sv
rtl/serial_bank_mapper_with_frame_timer_core.sv
tb/tb_serial_bank_mapper_with_frame_timer_core.sv
